// ===== rtl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared widths, reset values and codes for the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int SLOT_W        = 6;
  localparam int CFG_W         = 7;
  localparam int MAX_SLOTS_DEF = 64;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 7'd64;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/slot_pool_allocator_oldest_reuse.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_oldest_reuse
// Slot pool with lowest-free grant and oldest-first reclaim when full.
// ----------------------------------------------------------------------------
// Request channel: in_valid / in_stall with cmd and release_slot. Allocate
// grants the lowest free slot below slots_in_use; when none is free the
// oldest busy slot is reclaimed and flagged. Release frees a busy slot.
// Result channel: out_valid / out_stall with ok, slot and reclaimed, one
// beat per request, in request order.
// Config: cfg_we / cfg_wdata writes slots_in_use; write only while idle.
// Timing: a request beat is taken only in the idle state. The request then
// passes through the scan and update states; out_valid rises on commit in
// the update state, and the next request is taken only back in idle. The
// age list is a linked list in two link memories (forward and backward),
// read in the scan state and rewritten in the update state.
// A result waiting under out_stall does not block the next request; only
// the commit of the following result waits for the output register.
// Reset: all slots free, slots_in_use = 64, list empty. The link memories
// hold only entries of busy slots, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_pool_allocator_oldest_reuse
  import spa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [SLOT_W-1:0] release_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [SLOT_W-1:0] slot,
  output logic              reclaimed,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  state_t           state, state_next;
  cmd_t             cmd_q;
  logic [SLOT_W-1:0] rel_q;
  logic [CFG_W-1:0] slots_in_use;

  logic [MAX_SLOTS-1:0] busy;
  logic [CNT_W-1:0]     busy_count;
  logic [IW-1:0]        head, tail;

  logic          found_q;
  logic [IW-1:0] free_q;
  logic          hit;
  logic [IW-1:0] hit_idx;

  // age list links
  logic [IW-1:0] fwd_link  [MAX_SLOTS];
  logic [IW-1:0] back_link [MAX_SLOTS];
  logic [IW-1:0] fwd_rd, back_rd;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          fwd_we, back_we;
  logic [IW-1:0] fwd_wa, fwd_wd, back_wa, back_wd;

  logic          in_beat, commit;
  logic          rel_in_range, rel_ok, grant_new, grant_old;
  logic [IW-1:0] rel_idx;

  logic              res_ok, res_reclaimed;
  logic [SLOT_W-1:0] res_slot;

  assign in_beat      = in_valid && !in_stall;
  assign rel_in_range = 32'(rel_q) < 32'(MAX_SLOTS);
  assign rel_idx      = IW'(rel_q);
  assign rel_ok       = (cmd_q == CMD_RELEASE) && rel_in_range && busy[rel_idx];
  assign grant_new    = (cmd_q == CMD_ALLOC) && found_q;
  assign grant_old    = (cmd_q == CMD_ALLOC) && !found_q &&
                        (slots_in_use != '0) && (busy_count != '0);

  // lowest free slot among those taking part
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i] && (i < int'(slots_in_use))) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the output register can take the beat
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = (cmd_q == CMD_RELEASE) ? rel_idx : head;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q <= cmd_t'(cmd);
      rel_q <= release_slot;
    end
    if (rd_en) begin
      found_q <= hit;
      free_q  <= hit_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_rd  <= fwd_link[rd_addr];
      back_rd <= back_link[rd_addr];
    end
    if (fwd_we) begin
      fwd_link[fwd_wa] <= fwd_wd;
    end
    if (back_we) begin
      back_link[back_wa] <= back_wd;
    end
  end

  // link writes for append, move-to-tail and unlink
  always_comb begin
    fwd_we  = 1'b0;
    back_we = 1'b0;
    fwd_wa  = tail;
    fwd_wd  = free_q;
    back_wa = free_q;
    back_wd = tail;
    if (commit) begin
      if (grant_new) begin
        fwd_we  = (busy_count != '0);
        back_we = (busy_count != '0);
      end else if (grant_old) begin
        fwd_we  = (busy_count > CNT_W'(1));
        back_we = (busy_count > CNT_W'(1));
        fwd_wd  = head;
        back_wa = head;
      end else if (rel_ok && (head != rel_idx) && (tail != rel_idx)) begin
        fwd_we  = 1'b1;
        back_we = 1'b1;
        fwd_wa  = back_rd;
        fwd_wd  = fwd_rd;
        back_wa = fwd_rd;
        back_wd = back_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= '0;
      busy_count <= '0;
    end else if (commit) begin
      if (grant_new) begin
        busy[free_q] <= 1'b1;
        busy_count   <= busy_count + CNT_W'(1);
        tail         <= free_q;
        if (busy_count == '0) begin
          head <= free_q;
        end
      end else if (grant_old) begin
        if (busy_count > CNT_W'(1)) begin
          head <= fwd_rd;
          tail <= head;
        end
      end else if (rel_ok) begin
        busy[rel_idx] <= 1'b0;
        busy_count    <= busy_count - CNT_W'(1);
        if (head == rel_idx) begin
          head <= fwd_rd;
        end
        if (tail == rel_idx) begin
          tail <= back_rd;
        end
      end
    end
  end

  always_comb begin
    res_ok        = 1'b0;
    res_slot      = '0;
    res_reclaimed = 1'b0;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (grant_new) begin
          res_ok   = 1'b1;
          res_slot = SLOT_W'(free_q);
        end else if (grant_old) begin
          res_ok        = 1'b1;
          res_slot      = SLOT_W'(head);
          res_reclaimed = 1'b1;
        end
      end
      CMD_RELEASE: begin
        res_ok   = rel_ok;
        res_slot = rel_q;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      ok        <= res_ok;
      slot      <= res_slot;
      reclaimed <= res_reclaimed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(busy_count) <= 32'(MAX_SLOTS))
    else $error("busy count above pool size");

  a_count_matches_bits: assert property (@(posedge clk) disable iff (rst)
    (busy_count == '0) == (busy == '0))
    else $error("busy count and busy bits disagree");

  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    commit && grant_new |-> !busy[free_q])
    else $error("granted slot already busy");

  a_reclaim_keeps_count: assert property (@(posedge clk) disable iff (rst)
    commit && grant_old |=> $stable(busy_count))
    else $error("reclaim changed busy count");
`endif

endmodule
